// File: hw/rtl/radsimp_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and the microcode table of the radical simplifier.
// Depends on nothing; every other file of the block imports it.
package radsimp_pkg;

  localparam int VALUE_BITS = 32;
  // A trial factor never passes the square root of the magnitude by more than one.
  localparam int FACT_W     = (VALUE_BITS + 1) / 2 + 1;
  localparam int CNT_W      = $clog2(VALUE_BITS + 1);
  localparam int OUTER_W    = 16;
  localparam int INNER_W    = 31;
  localparam int WIDE_W     = 64;
  localparam int PC_W       = 4;
  localparam int ACT_W      = 3;
  localparam int COND_W     = 4;

  typedef logic [PC_W-1:0]   pc_t;
  typedef logic [ACT_W-1:0]  act_t;
  typedef logic [COND_W-1:0] cond_t;

  typedef struct packed {
    act_t  act;
    cond_t cond;
    pc_t   target;
  } uword_t;

  // Datapath actions.
  localparam act_t A_NONE  = 3'd0;
  localparam act_t A_LOAD  = 3'd1;
  localparam act_t A_DIV   = 3'd2;
  localparam act_t A_TAKEQ = 3'd3;
  localparam act_t A_NEXTF = 3'd4;
  localparam act_t A_FINAL = 3'd5;
  localparam act_t A_PUSH  = 3'd6;

  // Jump conditions; when the condition holds the step counter loads the target.
  localparam cond_t C_NONE      = 4'd0;
  localparam cond_t C_ALWAYS    = 4'd1;
  localparam cond_t C_NO_IN     = 4'd2;
  localparam cond_t C_N_LE1     = 4'd3;
  localparam cond_t C_DIV_BUSY  = 4'd4;
  localparam cond_t C_F_GT_Q    = 4'd5;
  localparam cond_t C_REM_NZ    = 4'd6;
  localparam cond_t C_REM_Z     = 4'd7;
  localparam cond_t C_SLOT_BUSY = 4'd8;

  // Program steps.
  localparam pc_t S_IDLE  = 4'd0;
  localparam pc_t S_CHK   = 4'd1;
  localparam pc_t S_TRY   = 4'd2;
  localparam pc_t S_TRYW  = 4'd3;
  localparam pc_t S_TEST  = 4'd4;
  localparam pc_t S_REM   = 4'd5;
  localparam pc_t S_TAKE  = 4'd6;
  localparam pc_t S_AGAIN = 4'd7;
  localparam pc_t S_AGW   = 4'd8;
  localparam pc_t S_AREM  = 4'd9;
  localparam pc_t S_NEXTF = 4'd10;
  localparam pc_t S_LAST  = 4'd11;
  localparam pc_t S_OUT   = 4'd12;
  localparam pc_t S_RET   = 4'd13;

  function automatic uword_t ucode(input pc_t pc);
    uword_t w;
    case (pc)
      S_IDLE:  w = '{act: A_LOAD,  cond: C_NO_IN,     target: S_IDLE};
      S_CHK:   w = '{act: A_NONE,  cond: C_N_LE1,     target: S_OUT};
      S_TRY:   w = '{act: A_DIV,   cond: C_NONE,      target: S_IDLE};
      S_TRYW:  w = '{act: A_NONE,  cond: C_DIV_BUSY,  target: S_TRYW};
      S_TEST:  w = '{act: A_NONE,  cond: C_F_GT_Q,    target: S_LAST};
      S_REM:   w = '{act: A_NONE,  cond: C_REM_NZ,    target: S_NEXTF};
      S_TAKE:  w = '{act: A_TAKEQ, cond: C_NONE,      target: S_IDLE};
      S_AGAIN: w = '{act: A_DIV,   cond: C_NONE,      target: S_IDLE};
      S_AGW:   w = '{act: A_NONE,  cond: C_DIV_BUSY,  target: S_AGW};
      S_AREM:  w = '{act: A_NONE,  cond: C_REM_Z,     target: S_TAKE};
      S_NEXTF: w = '{act: A_NEXTF, cond: C_ALWAYS,    target: S_TRY};
      S_LAST:  w = '{act: A_FINAL, cond: C_NONE,      target: S_IDLE};
      S_OUT:   w = '{act: A_PUSH,  cond: C_SLOT_BUSY, target: S_OUT};
      S_RET:   w = '{act: A_NONE,  cond: C_ALWAYS,    target: S_IDLE};
      default: w = '{act: A_NONE,  cond: C_ALWAYS,    target: S_IDLE};
    endcase
    return w;
  endfunction

endpackage

// File: hw/rtl/radsimp_if.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the radical simplifier's input and result words.
// Depends on radsimp_pkg for the field widths.
interface radsimp_in_if;
  import radsimp_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [VALUE_BITS-1:0]  radicand_in;
  logic                          imag_in;

  modport source (output valid, output radicand_in, output imag_in, input ready);
  modport sink   (input valid, input radicand_in, input imag_in, output ready);
endinterface

interface radsimp_out_if;
  import radsimp_pkg::*;

  logic               valid;
  logic               ready;
  logic               imaginary;
  logic [OUTER_W-1:0] outer_coeff;
  logic [INNER_W-1:0] radicand_out;

  modport source (output valid, output imaginary, output outer_coeff, output radicand_out,
                  input ready);
  modport sink   (input valid, input imaginary, input outer_coeff, input radicand_out,
                  output ready);
endinterface

// File: hw/rtl/radsimp_div.sv
`timescale 1ns / 1ps
// Restoring shift-subtract divider, one quotient bit per cycle.
// Depends on radsimp_pkg for the dividend and divisor widths.
module radsimp_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [radsimp_pkg::VALUE_BITS-1:0] dividend,
  input  logic [radsimp_pkg::FACT_W-1:0]     divisor,
  output logic                         busy,
  output logic [radsimp_pkg::VALUE_BITS-1:0] quot,
  output logic [radsimp_pkg::FACT_W-1:0]     rem
);
  import radsimp_pkg::*;

  logic [VALUE_BITS-1:0] qr;
  logic [FACT_W-1:0]     rm;
  logic [FACT_W-1:0]     dsr;
  logic [CNT_W-1:0]      cnt;
  logic [FACT_W:0]       rem_sh;
  logic [FACT_W:0]       diff;
  logic                  ge;

  // The partial remainder stays below the divisor, so the shifted value fits one extra bit.
  always_comb begin
    rem_sh = {rm, qr[VALUE_BITS-1]};
    ge     = rem_sh >= {1'b0, dsr};
    diff   = rem_sh - {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(VALUE_BITS);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == CNT_W'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      qr  <= dividend;
      rm  <= '0;
      dsr <= divisor;
    end else if (busy) begin
      qr <= {qr[VALUE_BITS-2:0], ge};
      rm <= ge ? diff[FACT_W-1:0] : rem_sh[FACT_W-1:0];
    end
  end

  assign quot = qr;
  assign rem  = rm;

endmodule

// File: hw/rtl/radical_simplifier_top.sv
`timescale 1ns / 1ps
// Top level of the radical simplifier: microcode sequencer, factoring datapath, result register.
// Depends on radsimp_pkg, radsimp_if and radsimp_div.
//
// The block takes one word at a time and rewrites sqrt(radicand_in) as
// outer_coeff * sqrt(radicand_out), with the imaginary flag set for a negative input or a set
// imag_in; an empty product is reported as 0, so 0 and plus or minus one give zero for both.
// Factoring is trial division from 2 upwards on one shared divider that makes one quotient bit
// a cycle; each candidate factor costs one division, and every prime factor found costs a
// further division. The candidates run up to the square root of what is left of the
// magnitude, so the time an item takes grows with the number of candidates tried and of prime
// factors found. The result sits in an output register, so a new word is taken while the
// previous result still waits to be read.
module radical_simplifier_top (
  input logic          clk,
  input logic          rst,
  radsimp_in_if.sink   din,
  radsimp_out_if.source dout
);
  import radsimp_pkg::*;

  pc_t                   pc;
  pc_t                   pc_next;
  uword_t                uw;
  logic                  take;

  logic [VALUE_BITS-1:0] n;
  logic [FACT_W-1:0]     f;
  logic                  par;
  logic                  imag;
  logic [OUTER_W-1:0]    outer;
  logic [INNER_W-1:0]    inner;

  logic                  out_valid;
  logic                  out_imag;
  logic [OUTER_W-1:0]    out_outer;
  logic [INNER_W-1:0]    out_inner;

  logic                  div_busy;
  logic [VALUE_BITS-1:0] quot;
  logic [FACT_W-1:0]     rem;

  logic [VALUE_BITS-1:0] raw;
  logic                  neg;
  logic [VALUE_BITS-1:0] mag;
  logic [WIDE_W-1:0]     f_wide;
  logic [WIDE_W-1:0]     n_wide;
  logic [OUTER_W-1:0]    f_o;
  logic [2*OUTER_W-1:0]  prod_o;
  logic [OUTER_W-1:0]    outer_mul;
  logic [INNER_W-1:0]    inner_op;
  logic [2*INNER_W-1:0]  prod_i;
  logic [INNER_W-1:0]    inner_mul;
  logic                  in_fire;
  logic                  slot_busy;

  radsimp_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (uw.act == A_DIV),
    .dividend (n),
    .divisor  (f),
    .busy     (div_busy),
    .quot     (quot),
    .rem      (rem)
  );

  assign din.ready = (pc == S_IDLE);
  assign in_fire   = din.valid && (pc == S_IDLE);
  assign slot_busy = out_valid && !dout.ready;

  // Sequencer: one control word a step, jump on the selected condition, else fall through.
  always_comb begin
    uw = ucode(pc);
    case (uw.cond)
      C_NONE:      take = 1'b0;
      C_ALWAYS:    take = 1'b1;
      C_NO_IN:     take = !din.valid;
      C_N_LE1:     take = n <= VALUE_BITS'(1);
      C_DIV_BUSY:  take = div_busy;
      C_F_GT_Q:    take = VALUE_BITS'(f) > quot;
      C_REM_NZ:    take = rem != '0;
      C_REM_Z:     take = rem == '0;
      C_SLOT_BUSY: take = slot_busy;
      default:     take = 1'b0;
    endcase
    pc_next = take ? uw.target : pc + 1'b1;
  end

  always_comb begin
    raw    = din.radicand_in;
    neg    = raw[VALUE_BITS-1];
    mag    = neg ? (~raw + VALUE_BITS'(1)) : raw;
    f_wide = WIDE_W'(f);
    n_wide = WIDE_W'(n);
    f_o    = f_wide[OUTER_W-1:0];
    prod_o = outer * f_o;
    // Only the low bits of each product are kept, so the operands are cut to the field width.
    outer_mul = (outer == '0) ? f_o : prod_o[OUTER_W-1:0];
    inner_op  = (uw.act == A_FINAL) ? n_wide[INNER_W-1:0] : f_wide[INNER_W-1:0];
    prod_i    = inner * inner_op;
    inner_mul = (inner == '0) ? inner_op : prod_i[INNER_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (uw.act == A_PUSH && !slot_busy) begin
        out_valid <= 1'b1;
      end else if (dout.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (uw.act)
      A_LOAD: begin
        if (in_fire) begin
          n     <= mag;
          f     <= FACT_W'(2);
          par   <= 1'b0;
          imag  <= din.imag_in | neg;
          outer <= '0;
          inner <= '0;
        end
      end
      A_TAKEQ: begin
        // The second of each pair of equal factors goes outside the root.
        n <= quot;
        if (par) begin
          outer <= outer_mul;
          par   <= 1'b0;
        end else begin
          par <= 1'b1;
        end
      end
      A_NEXTF: begin
        if (par) begin
          inner <= inner_mul;
        end
        par <= 1'b0;
        f   <= f + 1'b1;
      end
      A_FINAL: begin
        if (n > VALUE_BITS'(1)) begin
          inner <= inner_mul;
        end
      end
      A_PUSH: begin
        if (!slot_busy) begin
          out_imag  <= imag;
          out_outer <= outer;
          out_inner <= inner;
        end
      end
      default: begin
      end
    endcase
  end

  assign dout.valid        = out_valid;
  assign dout.imaginary    = out_imag;
  assign dout.outer_coeff  = out_outer;
  assign dout.radicand_out = out_inner;

endmodule

// File: hw/rtl/radsimp_chk.sv
`timescale 1ns / 1ps
// Port-level checker for the radical simplifier, attached to the top level by a bind.
// Depends on radsimp_pkg and on the port names of radical_simplifier_top.
module radsimp_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic                              imaginary,
  input logic [radsimp_pkg::OUTER_W-1:0]   outer_coeff,
  input logic [radsimp_pkg::INNER_W-1:0]   radicand_out
);
  import radsimp_pkg::*;

  logic       in_fire;
  logic       out_fire;
  logic [1:0] pending;

  assign in_fire  = in_valid && in_ready;
  assign out_fire = out_valid && out_ready;

  // Words taken but not yet delivered: one at work and one in the result register at most.
  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else begin
      pending <= pending + {1'b0, in_fire} - {1'b0, out_fire};
    end
  end

  a_valid_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result word withdrawn while stalled");

  a_payload_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(imaginary) && $stable(outer_coeff)
                                && $stable(radicand_out))
    else $error("result word changed while stalled");

  a_one_at_work: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> !in_ready)
    else $error("input taken again while a word is still being factored");

  a_no_invented: assert property (@(posedge clk) disable iff (rst)
    out_fire |-> pending != 2'd0)
    else $error("result word delivered with no word outstanding");

  a_bounded: assert property (@(posedge clk) disable iff (rst)
    pending <= 2'd2)
    else $error("more than two words outstanding");

endmodule

bind radical_simplifier_top radsimp_chk u_radsimp_chk (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (din.valid),
  .in_ready     (din.ready),
  .out_valid    (dout.valid),
  .out_ready    (dout.ready),
  .imaginary    (dout.imaginary),
  .outer_coeff  (dout.outer_coeff),
  .radicand_out (dout.radicand_out)
);
